>>> hw/rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// Frame slot pool package
// Shared sizes, request types and slot index helpers for the frame slot pool.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int SLOT_COUNT  = 5;
  localparam int TAG_BITS    = 32;
  localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FIELD_W     = 32;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 72;

  localparam logic [SLOT_IDX_W-1:0] SLOT_LAST  = SLOT_IDX_W'(SLOT_COUNT - 1);
  localparam logic [3:0]            COUNT_MAX  = 4'd15;

  // Request codes as they arrive on the input channel.
  localparam logic [2:0] MODE_ACQ_WRITE  = 3'd0;
  localparam logic [2:0] MODE_ACQ_LATEST = 3'd1;
  localparam logic [2:0] MODE_ACQ_TAG    = 3'd2;
  localparam logic [2:0] MODE_PUBLISH    = 3'd3;
  localparam logic [2:0] MODE_RELEASE    = 3'd4;
  localparam logic [2:0] MODE_CLEAR      = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACQ_WRITE,
    OP_ACQ_LATEST,
    OP_ACQ_TAG,
    OP_PUBLISH,
    OP_RELEASE,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [SLOT_IDX_W-1:0]   slot;
    logic [TAG_BITS-1:0]     tag;
  } op_req_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic enabled;
    logic busy;
  } bk_status_t;

  function automatic logic [SLOT_IDX_W-1:0] slot_inc(input logic [SLOT_IDX_W-1:0] idx);
    slot_inc = (idx == SLOT_LAST) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [SLOT_IDX_W-1:0] slot_dec(input logic [SLOT_IDX_W-1:0] idx);
    slot_dec = (idx == '0) ? SLOT_LAST : idx - 1'b1;
  endfunction

endpackage

>>> hw/rtl/fsp_front.sv
// ----------------------------------------------------------------------------
// Frame slot pool front end
// Accepts requests and classifies them into internal operations.
// ----------------------------------------------------------------------------
module fsp_front
  import fsp_pkg::*;
(
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [2:0]            s_tuser,
  input  q_status_t             q_status,
  output logic                  push,
  output op_req_t               push_req
);

  logic [3:0]       sel;
  logic [FIELD_W-1:0] tag_in;
  logic             sel_ok;

  assign sel      = s_tdata[3:0];
  assign tag_in   = s_tdata[35:4];
  assign sel_ok   = (int'(sel) < SLOT_COUNT);
  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  // Out-of-range publish and release requests become no-ops here.
  always_comb begin
    push_req.tag  = TAG_BITS'(tag_in);
    push_req.slot = sel_ok ? SLOT_IDX_W'(sel) : '0;
    unique case (s_tuser)
      MODE_ACQ_WRITE:  push_req.kind = OP_ACQ_WRITE;
      MODE_ACQ_LATEST: push_req.kind = OP_ACQ_LATEST;
      MODE_ACQ_TAG:    push_req.kind = OP_ACQ_TAG;
      MODE_PUBLISH:    push_req.kind = sel_ok ? OP_PUBLISH : OP_NONE;
      MODE_RELEASE:    push_req.kind = sel_ok ? OP_RELEASE : OP_NONE;
      MODE_CLEAR:      push_req.kind = OP_CLEAR;
      default:         push_req.kind = OP_NONE;
    endcase
  end

endmodule

>>> hw/rtl/fsp_queue.sv
// ----------------------------------------------------------------------------
// Frame slot pool request queue
// Short FIFO of classified requests between the front end and the engine.
// ----------------------------------------------------------------------------
module fsp_queue
  import fsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_req_t   push_req,
  input  logic      pop,
  output op_req_t   pop_req,
  output q_status_t q_status
);

  op_req_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign q_status.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (fill == '0);
  assign pop_req        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

>>> hw/rtl/fsp_engine.sv
// ----------------------------------------------------------------------------
// Frame slot pool engine
// Holds the slot state and carries out one request at a time, one slot a cycle.
// ----------------------------------------------------------------------------
module fsp_engine
  import fsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  q_status_t              q_status,
  input  op_req_t                pop_req,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic [0:0]             m_tuser,
  output bk_status_t             bk_status
);

  bk_state_t               state;
  bk_state_t               state_next;
  logic                    enabled;
  logic                    slot_ready [SLOT_COUNT];
  logic [3:0]              reader_count [SLOT_COUNT];
  logic [TAG_BITS-1:0]     slot_tag [SLOT_COUNT];
  logic [SLOT_IDX_W-1:0]   write_pointer;
  logic [FIELD_W-1:0]      write_total;

  op_kind_t                cur_kind;
  logic [TAG_BITS-1:0]     cur_tag;
  logic [SLOT_IDX_W-1:0]   idx;
  logic [SLOT_IDX_W-1:0]   tries;

  logic                    out_valid;
  logic                    out_found;
  logic [3:0]              out_slot;
  logic [FIELD_W-1:0]      out_tag;
  logic [FIELD_W-1:0]      out_total;

  logic                    hit;
  logic                    last;
  logic [TAG_BITS-1:0]     shown;
  logic [SLOT_IDX_W-1:0]   start_idx;

  assign pop       = (state == BK_IDLE) && !q_status.empty && (!out_valid || m_tready);
  assign m_tvalid  = out_valid;
  assign m_tuser   = out_found;
  assign m_tdata   = {4'b0, out_total, out_tag, out_slot};
  assign bk_status.enabled = enabled;
  assign bk_status.busy    = (state == BK_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (pop)  state_next = BK_EXEC;
      BK_EXEC: if (last) state_next = BK_IDLE;
      default:           state_next = BK_IDLE;
    endcase
  end

  // Step decode: does the slot under the index satisfy the request, and is
  // this the final step.
  always_comb begin
    hit   = 1'b0;
    last  = 1'b1;
    shown = '0;
    unique case (cur_kind)
      OP_ACQ_WRITE: begin
        hit  = (reader_count[idx] == 4'd0);
        last = hit || (tries == '0);
      end
      OP_ACQ_LATEST: begin
        hit   = slot_ready[idx];
        last  = hit || (tries == '0);
        shown = slot_tag[idx];
      end
      OP_ACQ_TAG: begin
        hit   = slot_ready[idx] && (slot_tag[idx] == cur_tag);
        last  = hit || (tries == '0);
        shown = slot_tag[idx];
      end
      OP_PUBLISH: begin
        hit   = 1'b1;
        shown = cur_tag;
      end
      OP_RELEASE: hit = (reader_count[idx] != 4'd0);
      OP_CLEAR:   hit = 1'b1;
      OP_NONE:    hit = 1'b0;
      default:    hit = 1'b0;
    endcase
    if (!enabled) begin
      hit  = 1'b0;
      last = 1'b1;
    end
  end

  always_comb begin
    unique case (pop_req.kind)
      OP_ACQ_WRITE:  start_idx = write_pointer;
      OP_ACQ_LATEST: start_idx = slot_dec(write_pointer);
      OP_PUBLISH,
      OP_RELEASE:    start_idx = pop_req.slot;
      default:       start_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      enabled       <= 1'b0;
      write_pointer <= '0;
      write_total   <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_ready[i]   <= 1'b0;
        reader_count[i] <= 4'd0;
      end
    end else begin
      state <= state_next;
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (state == BK_EXEC) begin
        if (last) begin
          out_valid <= 1'b1;
        end
        if (enabled) begin
          unique case (cur_kind)
            OP_ACQ_WRITE: begin
              write_pointer <= slot_inc(idx);
              if (hit) begin
                slot_ready[idx] <= 1'b0;
                write_total     <= write_total + 1'b1;
              end
            end
            OP_ACQ_LATEST,
            OP_ACQ_TAG: begin
              if (hit && reader_count[idx] != COUNT_MAX) begin
                reader_count[idx] <= reader_count[idx] + 1'b1;
              end
            end
            OP_PUBLISH: slot_ready[idx] <= 1'b1;
            OP_RELEASE: begin
              if (hit) begin
                reader_count[idx] <= reader_count[idx] - 1'b1;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_ready[i]   <= 1'b0;
                reader_count[i] <= 4'd0;
              end
            end
            default: ;
          endcase
        end
      end
      // Enabling a disabled pool starts it afresh.
      if (cfg_wr_en) begin
        enabled <= cfg_wr_data;
        if (cfg_wr_data && !enabled) begin
          write_pointer <= '0;
          write_total   <= '0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ready[i]   <= 1'b0;
            reader_count[i] <= 4'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind <= pop_req.kind;
      cur_tag  <= pop_req.tag;
      idx      <= start_idx;
      tries    <= SLOT_LAST;
    end else if (state == BK_EXEC) begin
      idx   <= (cur_kind == OP_ACQ_LATEST) ? slot_dec(idx) : slot_inc(idx);
      tries <= tries - 1'b1;
      if (enabled && cur_kind == OP_PUBLISH) begin
        slot_tag[idx] <= cur_tag;
      end
      if (last) begin
        out_found <= hit;
        out_slot  <= hit ? 4'(idx) : 4'd0;
        out_tag   <= hit ? FIELD_W'(shown) : '0;
        out_total <= (hit && cur_kind == OP_ACQ_WRITE) ? write_total + 1'b1 : write_total;
      end
    end
  end

endmodule

>>> hw/rtl/frame_slot_pool_manager_unit.sv
// ----------------------------------------------------------------------------
// Frame slot pool manager
// Reference-counted ring of frame-buffer slots with write, read and release.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the mode, s_tdata the
// slot select and frame tag. Each request yields exactly one result on the
// m_ channel: m_tuser says whether the request succeeded, m_tdata gives the
// slot, its tag and the running count of write acquisitions.
// The single configuration bit is written with cfg_wr_en; setting it while
// the pool is off clears every slot, the write pointer and the count.
// A request is taken into a two-entry queue in the cycle it is accepted.
// The engine then pulls it and visits one slot per cycle: acquire write,
// acquire latest and acquire by tag scan until a slot fits or every slot
// has been tried; publish, release and clear visit a single slot. The
// engine pulls the next request only once its scan is over and the
// output register is free or being read.
// When the receiver stalls the result is held in the output register; the
// queue keeps accepting requests until it is full, then s_tready drops.
// After reset the pool is off, all slots are empty and the queue is empty.
// ----------------------------------------------------------------------------
module frame_slot_pool_manager_unit
  import fsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,   // pool_enabled
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,       // slot_select[3:0], frame_tag[35:4]
  input  logic [2:0]            s_tuser,       // mode[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,       // granted_slot[3:0], granted_tag[35:4],
                                               // frames_written[67:36]
  output logic [0:0]            m_tuser        // found[0]
);

  q_status_t  q_status;
  bk_status_t bk_status;
  logic       push;
  logic       pop;
  op_req_t    push_req;
  op_req_t    pop_req;

  // Front end: accepts and classifies each request.
  fsp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .push     (push),
    .push_req (push_req)
  );

  // Decoupling queue so that front and engine stall independently.
  fsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .q_status (q_status)
  );

  // Engine: slot state, scan sequencer and result register.
  fsp_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_status),
    .pop_req     (pop_req),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .bk_status   (bk_status)
  );

`ifndef ASSERT_OFF
  // The engine only pulls a request that is actually queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("request pulled from an empty queue");

  // A scan never runs while a result still waits in the output register.
  a_exec_out_free: assert property (@(posedge clk) disable iff (rst)
    bk_status.busy |-> !m_tvalid)
    else $error("engine busy while a result is pending");

  // A successful result can only come from an enabled pool.
  a_found_enabled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> bk_status.enabled)
    else $error("success reported while the pool is disabled");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame slot pool manager testbench
// Drives mode, slot and tag requests into the pool manager and checks every
// result against a behavioural model of the slot ring. The model tracks ready
// flags, reader counts, tags and the write pointer. The run covers a short
// directed sequence and then phases of random producer and consumer traffic.
// Both sides of the stream idle at random. Between phases the pool enable is
// rewritten.
// ----------------------------------------------------------------------------
module testbench;
  import fsp_pkg::*;

  localparam logic [2:0]  MODE_SPARE_6    = 3'd6;
  localparam logic [2:0]  MODE_SPARE_7    = 3'd7;
  localparam int unsigned HOLD_OFF_AT     = 350;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned CALM_FIRST      = 900;
  localparam int unsigned CALM_LAST       = 1100;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [31:0] total;
  } grant_t;

  // Model of the slot ring plus the queue of results still to arrive.
  class slot_pool_scoreboard;
    bit                  pool_on;
    bit                  ready [SLOT_COUNT];
    logic [3:0]          readers [SLOT_COUNT];
    logic [TAG_BITS-1:0] tags [SLOT_COUNT];
    int unsigned         write_ptr;
    logic [31:0]         write_count;
    grant_t              awaited_grants [$];
    grant_t              latest_guess;
    int unsigned         failures;
    int unsigned         checked;
    int unsigned         granted;
    int unsigned         full_refusals;
    int unsigned         saturated_takes;

    function new();
      pool_on = 1'b0;
      empty_slots();
      foreach (tags[i]) tags[i] = '0;
      write_ptr = 0;
      write_count = '0;
      failures = 0;
      checked = 0;
      granted = 0;
      full_refusals = 0;
      saturated_takes = 0;
    endfunction

    function void empty_slots();
      foreach (ready[i]) begin
        ready[i] = 1'b0;
        readers[i] = '0;
      end
    endfunction

    // Turning the pool on from off wipes the slots, the pointer and the count.
    function void set_enable(bit value);
      if (value && !pool_on) begin
        empty_slots();
        write_ptr = 0;
        write_count = '0;
      end
      pool_on = value;
    endfunction

    function void add_reader(int unsigned s);
      if (readers[s] == COUNT_MAX) saturated_takes++;
      else readers[s]++;
    endfunction

    function void account_request(logic [2:0] mode, logic [3:0] sel, logic [31:0] tag);
      grant_t      g;
      int unsigned s;
      bit          hit;
      g = '0;
      hit = 1'b0;
      if (pool_on) begin
        case (mode)
          MODE_ACQ_WRITE: begin
            // The pointer moves past every slot tried, busy or not.
            for (int i = 0; i < SLOT_COUNT && !hit; i++) begin
              s = write_ptr;
              write_ptr = (s + 1) % SLOT_COUNT;
              if (readers[s] == 0) begin
                ready[s] = 1'b0;
                write_count++;
                hit = 1'b1;
                g.slot = 4'(s);
              end
            end
            if (!hit) full_refusals++;
          end
          MODE_ACQ_LATEST: begin
            // Newest ready slot: walk backwards from just behind the pointer.
            for (int i = 1; i <= SLOT_COUNT && !hit; i++) begin
              s = (write_ptr + SLOT_COUNT - i) % SLOT_COUNT;
              if (ready[s]) begin
                add_reader(s);
                hit = 1'b1;
                g.slot = 4'(s);
                g.tag = tags[s];
              end
            end
          end
          MODE_ACQ_TAG: begin
            for (int i = 0; i < SLOT_COUNT && !hit; i++) begin
              if (ready[i] && tags[i] == tag) begin
                add_reader(i);
                hit = 1'b1;
                g.slot = 4'(i);
                g.tag = tags[i];
              end
            end
          end
          MODE_PUBLISH: begin
            if (sel < SLOT_COUNT) begin
              tags[sel] = tag;
              ready[sel] = 1'b1;
              hit = 1'b1;
              g.slot = sel;
              g.tag = tag;
            end
          end
          MODE_RELEASE: begin
            if (sel < SLOT_COUNT && readers[sel] != 0) begin
              readers[sel]--;
              hit = 1'b1;
              g.slot = sel;
            end
          end
          MODE_CLEAR: begin
            empty_slots();
            hit = 1'b1;
          end
          default: ;
        endcase
      end
      g.found = hit;
      g.total = write_count;
      if (hit) granted++;
      latest_guess = g;
      awaited_grants.push_back(g);
    endfunction

    function void compare_grant(logic found, logic [3:0] slot, logic [31:0] tag,
                                logic [31:0] total);
      grant_t want;
      bit     bad;
      checked++;
      if (awaited_grants.size() == 0) begin
        $error("result with no request outstanding: found %0d slot %0d", found, slot);
        failures++;
        return;
      end
      want = awaited_grants.pop_front();
      bad = 1'b0;
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        bad = 1'b1;
      end
      if (slot !== want.slot) begin
        $error("granted_slot: expected %0d, got %0d", want.slot, slot);
        bad = 1'b1;
      end
      if (tag !== want.tag) begin
        $error("granted_tag: expected %08h, got %08h", want.tag, tag);
        bad = 1'b1;
      end
      if (total !== want.total) begin
        $error("frames_written: expected %0d, got %0d", want.total, total);
        bad = 1'b1;
      end
      if (bad) failures++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  slot_pool_scoreboard board = new();
  int unsigned         requests_sent = 0;
  int unsigned         hold_off_total = 0;
  logic [3:0]          written_slots [$];
  logic [3:0]          held_slots [$];
  logic [31:0]         recent_tags [$];

  frame_slot_pool_manager_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one request, with an optional random gap first. The handshake is
  // sampled on the falling edge, where both valid and ready are settled.
  task automatic send_request(input logic [2:0] mode, input logic [3:0] sel,
                              input logic [31:0] tag);
    bit taken;
    if (requests_sent < CALM_FIRST || requests_sent >= CALM_LAST) begin
      while ($urandom_range(99) < 14) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= IN_DATA_W'({tag, sel});
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    board.account_request(mode, sel, tag);
    requests_sent++;
  endtask

  // Stops offering and waits until every request has produced its result.
  task automatic drain_pool();
    s_tvalid <= 1'b0;
    while (board.awaited_grants.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 3) @(posedge clk);
  endtask

  task automatic set_pool_enable(input bit value);
    drain_pool();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_enable(value);
  endtask

  // Mostly well-formed traffic: producers publish the slot they were handed,
  // consumers release the slots they hold and look up tags that were
  // published. In a hoarding phase releases are rare, so reader counts climb
  // to saturation and the write scan finds every slot busy.
  task automatic random_request(input bit hoard);
    logic [2:0]  mode;
    logic [3:0]  sel;
    logic [31:0] tag;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    sel = 4'($urandom_range(SLOT_COUNT - 1));
    if ($urandom_range(99) < 12) sel = 4'($urandom_range(15));
    pick = $urandom_range(9);
    if (pick < 3) tag = 32'($urandom_range(7));
    else if (pick == 3) tag = $urandom_range(1) ? '1 : '0;
    else tag = $urandom;
    if (roll < 2) begin
      mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
    end else if (roll < (hoard ? 3 : 5)) begin
      mode = MODE_CLEAR;
    end else if (roll < 20) begin
      mode = MODE_ACQ_WRITE;
    end else if (roll < 38) begin
      mode = MODE_PUBLISH;
      if (written_slots.size() != 0 && $urandom_range(9) < 7) sel = written_slots.pop_front();
    end else if (roll < 56) begin
      mode = MODE_ACQ_LATEST;
    end else if (roll < 72) begin
      mode = MODE_ACQ_TAG;
      if (recent_tags.size() != 0 && $urandom_range(9) < 7)
        tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
    end else if (hoard && $urandom_range(9) != 0) begin
      mode = MODE_ACQ_LATEST;
    end else begin
      mode = MODE_RELEASE;
      if (held_slots.size() != 0 && $urandom_range(9) < 8) sel = held_slots.pop_front();
    end
    send_request(mode, sel, tag);
    if (board.latest_guess.found) begin
      case (mode)
        MODE_ACQ_WRITE: written_slots.push_back(board.latest_guess.slot);
        MODE_ACQ_LATEST, MODE_ACQ_TAG: held_slots.push_back(board.latest_guess.slot);
        MODE_PUBLISH: begin
          recent_tags.push_back(tag);
          if (recent_tags.size() > 8) void'(recent_tags.pop_front());
        end
        MODE_CLEAR: held_slots.delete();
        default: ;
      endcase
    end
  endtask

  // Result side: random stalls, one long hold-off so that the request queue
  // fills, and a calm stretch with ready held high.
  initial begin : result_sink
    int unsigned seen;
    int unsigned stall_left;
    bit          held_once;
    seen = 0;
    stall_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (seen == HOLD_OFF_AT && !held_once) begin
        stall_left = HOLD_OFF_CYCLES;
        held_once = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        hold_off_total++;
        m_tready <= 1'b0;
      end else if (seen >= CALM_FIRST && seen < CALM_LAST) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 14);
      end
      @(negedge clk);
      if (m_tvalid && m_tready) begin
        board.compare_grant(m_tuser[0], m_tdata[3:0], m_tdata[35:4], m_tdata[67:36]);
        seen++;
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pool still off after reset: everything is refused.
    send_request(MODE_ACQ_WRITE, 4'd0, 32'd0);
    send_request(MODE_ACQ_LATEST, 4'd0, 32'd0);
    send_request(MODE_PUBLISH, 4'd0, 32'h1234_5678);
    send_request(MODE_RELEASE, 4'd0, 32'd0);
    send_request(MODE_CLEAR, 4'd0, 32'd0);

    set_pool_enable(1'b1);
    // Nothing ready yet, then a write, publish and read cycle on two slots.
    send_request(MODE_ACQ_LATEST, 4'd0, 32'd0);
    send_request(MODE_ACQ_TAG, 4'd0, 32'd0);
    send_request(MODE_ACQ_WRITE, 4'd0, 32'd0);
    send_request(MODE_PUBLISH, 4'd0, 32'hFFFF_FFFF);
    send_request(MODE_ACQ_WRITE, 4'd0, 32'd0);
    send_request(MODE_PUBLISH, 4'd1, 32'd0);
    send_request(MODE_ACQ_LATEST, 4'd0, 32'd0);
    send_request(MODE_ACQ_TAG, 4'd0, 32'hFFFF_FFFF);
    send_request(MODE_ACQ_TAG, 4'd0, 32'h1234_5678);
    // A release with no reader left, and slot numbers past the ring.
    send_request(MODE_RELEASE, 4'd1, 32'd0);
    send_request(MODE_RELEASE, 4'd1, 32'd0);
    send_request(MODE_PUBLISH, 4'(SLOT_COUNT), 32'hA5A5_A5A5);
    send_request(MODE_PUBLISH, 4'd15, 32'h5A5A_5A5A);
    send_request(MODE_RELEASE, 4'd15, 32'd0);
    send_request(MODE_SPARE_6, 4'd0, 32'd0);
    send_request(MODE_SPARE_7, 4'd15, 32'hFFFF_FFFF);
    send_request(MODE_CLEAR, 4'd0, 32'd0);
    send_request(MODE_ACQ_LATEST, 4'd0, 32'd0);

    // Enabling an enabled pool must not wipe it.
    set_pool_enable(1'b1);
    repeat (300) random_request(1'b0);
    repeat (300) random_request(1'b1);
    set_pool_enable(1'b0);
    repeat (40) random_request(1'b0);
    set_pool_enable(1'b1);
    written_slots.delete();
    held_slots.delete();
    repeat (400) random_request(1'b0);
    repeat (250) random_request(1'b1);
    repeat (300) random_request(1'b0);
    drain_pool();

    $display("Run covered %0d requests and %0d results, %0d of them granted.",
             requests_sent, board.checked, board.granted);
    $display("Write scans with every slot busy: %0d; acquires at a full count: %0d; %0d %s",
             board.full_refusals, board.saturated_takes, hold_off_total,
             "cycles of result hold-off.");
    if (board.failures == 0) begin
      $display("** frame_slot_pool_manager_unit: PASSED **");
    end else begin
      $display("** frame_slot_pool_manager_unit: FAILED **");
    end
    $finish;
  end

  // Hard limit on simulated time in case a handshake hangs.
  initial begin : watchdog
    #2_000_000;
    $display("** frame_slot_pool_manager_unit: FAILED **");
    $finish;
  end

endmodule
